FILE: design/dsfm_pkg.sv
`default_nettype none

package dsfm_pkg;

    // table geometry
    localparam int MAX_TRACKS = 16;
    localparam int SLOT_W     = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CNT_W      = $clog2(MAX_TRACKS + 1);

    // field widths
    localparam int SECTOR_W = 32;
    localparam int POS_W    = 40;
    localparam int SIZE_W   = 12;
    localparam int INDEX_W  = 4;
    localparam int PROD_W   = SECTOR_W + SIZE_W;

    // queue between front and back, and result queue
    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // item function codes
    localparam logic FUNC_TRANSLATE = 1'b0;
    localparam logic FUNC_APPEND    = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_FIRST_SECTOR = 2'd0;
    localparam logic [1:0] CFG_FILE_BASE    = 2'd1;
    localparam logic [1:0] CFG_RAW_SIZE     = 2'd2;
    localparam logic [1:0] CFG_DATA_OFFSET  = 2'd3;

    localparam logic [SIZE_W-1:0] DEFAULT_RAW_SIZE_RST = 12'd2048;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // work handed from front to back
    typedef struct packed {
        status_t              status;
        logic                 used_default;
        logic [INDEX_W-1:0]   track_index;
        logic                 first_miss;
        logic [SECTOR_W-1:0]  delta;
        logic [SIZE_W-1:0]    raw_size;
        logic [POS_W-1:0]     base;
        logic [SIZE_W-1:0]    data_offset;
    } cmd_t;

    // one finished result
    typedef struct packed {
        status_t              status;
        logic                 used_default;
        logic [INDEX_W-1:0]   track_index;
        logic [POS_W-1:0]     byte_position;
        logic                 first_miss;
    } res_t;

    // low bits of a slot number as reported on track_index
    function automatic logic [INDEX_W-1:0] to_track_index(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W+INDEX_W-1:0] wide;
        wide = {{INDEX_W{1'b0}}, slot};
        return wide[INDEX_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/disc_sector_to_file_offset_mapper_unit.sv
// Disc sector to file offset mapper.
// Input channel: push/full. A beat is taken when push is high and full low.
// func selects translate (look up sector) or append (add a track range).
// Result channel: empty/pop. The oldest result sits on the result ports
// while empty is low and leaves on a clock edge with pop high.
// Every input beat gives exactly one result beat, in order.
// Configuration: cfg_we/cfg_index/cfg_data write the default geometry
// (first sector, file base, raw size, data offset); write only while idle.
// Steps from an input beat to its result, each registered in turn:
// capture, table compare, entry select and delta, multiply, then add into
// the result queue. One beat per cycle unless full; the range compare
// runs against all table entries at once and the multiply is one stage.
// A four-beat queue sits between the lookup and the arithmetic, and a
// four-beat result queue decouples the output; when the receiver stops
// popping, those queues fill and full rises to hold off the sender.
// Reset empties the track table, clears the miss flag and all queues,
// and loads the default geometry with a raw size of 2048.
`default_nettype none

module disc_sector_to_file_offset_mapper_unit
    import dsfm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic                func,
    input  wire logic [SECTOR_W-1:0] sector,
    input  wire logic [SECTOR_W-1:0] sector_count,
    input  wire logic [POS_W-1:0]    track_file_base,
    input  wire logic [SIZE_W-1:0]   track_raw_size,
    input  wire logic [SIZE_W-1:0]   track_data_offset,
    output logic                     empty,
    input  wire logic                pop,
    output logic [1:0]               status,
    output logic                     used_default,
    output logic [INDEX_W-1:0]       track_index,
    output logic [POS_W-1:0]         byte_position,
    output logic                     first_miss,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [POS_W-1:0]    cfg_data
);

    logic cmd_push, cmd_ready, cmd_valid, cmd_pop;
    cmd_t cmd_in, cmd_out;
    res_t res;

    // lookup and classification
    dsfm_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .func              (func),
        .sector            (sector),
        .sector_count      (sector_count),
        .track_file_base   (track_file_base),
        .track_raw_size    (track_raw_size),
        .track_data_offset (track_data_offset),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .cmd_push          (cmd_push),
        .cmd_data          (cmd_in),
        .cmd_ready         (cmd_ready)
    );

    // decoupling queue
    dsfm_cmd_queue u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_data  (cmd_in),
        .wr_ready (cmd_ready),
        .rd_valid (cmd_valid),
        .rd_data  (cmd_out),
        .rd_en    (cmd_pop)
    );

    // position arithmetic and result queue
    dsfm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_data  (cmd_out),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .res_data  (res)
    );

    // result fields
    always_comb
    begin
        status        = res.status;
        used_default  = res.used_default;
        track_index   = res.track_index;
        byte_position = res.byte_position;
        first_miss    = res.first_miss;
    end

endmodule

`default_nettype wire

FILE: design/dsfm_front.sv
`default_nettype none

module dsfm_front
    import dsfm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic                func,
    input  wire logic [SECTOR_W-1:0] sector,
    input  wire logic [SECTOR_W-1:0] sector_count,
    input  wire logic [POS_W-1:0]    track_file_base,
    input  wire logic [SIZE_W-1:0]   track_raw_size,
    input  wire logic [SIZE_W-1:0]   track_data_offset,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [POS_W-1:0]    cfg_data,
    output logic                     cmd_push,
    output cmd_t                     cmd_data,
    input  wire logic                cmd_ready
);

    // configuration registers
    logic [SECTOR_W-1:0] dflt_first_reg;
    logic [POS_W-1:0]    dflt_base_reg;
    logic [SIZE_W-1:0]   dflt_raw_reg;
    logic [SIZE_W-1:0]   dflt_offset_reg;

    // track table
    logic [SECTOR_W-1:0] ent_first_reg  [MAX_TRACKS];
    logic [SECTOR_W-1:0] ent_last_reg   [MAX_TRACKS];
    logic [POS_W-1:0]    ent_base_reg   [MAX_TRACKS];
    logic [SIZE_W-1:0]   ent_raw_reg    [MAX_TRACKS];
    logic [SIZE_W-1:0]   ent_offset_reg [MAX_TRACKS];
    logic [CNT_W-1:0]    ent_count_reg, ent_count_next;
    logic                miss_reported_reg, miss_reported_next;

    // stage 1: accepted item
    logic                s1_v_reg, s1_v_next;
    logic                s1_func_reg;
    logic [SECTOR_W-1:0] s1_sector_reg;
    logic [SECTOR_W-1:0] s1_count_reg;
    logic [POS_W-1:0]    s1_base_reg;
    logic [SIZE_W-1:0]   s1_raw_reg;
    logic [SIZE_W-1:0]   s1_offset_reg;

    // stage 2: classified item
    logic                  s2_v_reg, s2_v_next;
    logic                  s2_append_reg;
    status_t               s2_status_reg;
    logic [SLOT_W-1:0]     s2_slot_reg;
    logic [MAX_TRACKS-1:0] s2_hit_reg;
    logic [SECTOR_W-1:0]   s2_sector_reg;
    logic                  s2_dflt_reg;

    logic                  s2_fire, s1_adv, s1_fire, accept;
    logic                  app_empty, app_full, app_write;
    status_t               app_status;
    logic [SLOT_W-1:0]     app_slot;
    logic [SECTOR_W-1:0]   app_last;
    logic [MAX_TRACKS-1:0] hit;

    logic [MAX_TRACKS-1:0] hit_oh;
    logic                  found;
    logic [SLOT_W-1:0]     sel_idx;
    logic [SECTOR_W-1:0]   sel_first;
    logic [POS_W-1:0]      sel_base;
    logic [SIZE_W-1:0]     sel_raw;
    logic [SIZE_W-1:0]     sel_offset;
    logic                  is_miss;

    // handshake and stage advance
    always_comb
    begin
        s2_fire = s2_v_reg && cmd_ready;
        s1_adv  = !s2_v_reg || s2_fire;
        s1_fire = s1_v_reg && s1_adv;
        full    = s1_v_reg && !s1_adv;
        accept  = push && !full;
    end

    // append checks and range compare against the table
    always_comb
    begin
        app_empty = (s1_count_reg == '0);
        app_full  = (ent_count_reg >= CNT_W'(MAX_TRACKS));
        app_write = s1_fire && (s1_func_reg == FUNC_APPEND) && !app_empty && !app_full;
        app_slot  = ent_count_reg[SLOT_W-1:0];
        app_last  = s1_sector_reg + s1_count_reg - SECTOR_W'(1);
        if (app_empty)
            app_status = ST_EMPTY;
        else if (app_full)
            app_status = ST_FULL;
        else
            app_status = ST_OK;
        for (int i = 0; i < MAX_TRACKS; i++)
        begin
            hit[i] = (CNT_W'(i) < ent_count_reg)
                  && (s1_sector_reg >= ent_first_reg[i])
                  && (s1_sector_reg <= ent_last_reg[i]);
        end
    end

    // first matching entry and its geometry
    always_comb
    begin
        hit_oh     = s2_hit_reg & (~s2_hit_reg + MAX_TRACKS'(1));
        found      = |s2_hit_reg;
        sel_idx    = '0;
        sel_first  = '0;
        sel_base   = '0;
        sel_raw    = '0;
        sel_offset = '0;
        for (int i = 0; i < MAX_TRACKS; i++)
        begin
            if (hit_oh[i])
            begin
                sel_idx    = sel_idx    | SLOT_W'(i);
                sel_first  = sel_first  | ent_first_reg[i];
                sel_base   = sel_base   | ent_base_reg[i];
                sel_raw    = sel_raw    | ent_raw_reg[i];
                sel_offset = sel_offset | ent_offset_reg[i];
            end
        end
    end

    // command built for the back part
    always_comb
    begin
        is_miss  = !s2_append_reg && !s2_dflt_reg && !found;
        cmd_data = '0;
        if (s2_append_reg)
        begin
            cmd_data.status = s2_status_reg;
            if (s2_status_reg == ST_OK)
                cmd_data.track_index = to_track_index(s2_slot_reg);
        end
        else if (s2_dflt_reg)
        begin
            cmd_data.status       = ST_OK;
            cmd_data.used_default = 1'b1;
            cmd_data.delta        = s2_sector_reg - dflt_first_reg;
            cmd_data.raw_size     = dflt_raw_reg;
            cmd_data.base         = dflt_base_reg;
            cmd_data.data_offset  = dflt_offset_reg;
        end
        else if (found)
        begin
            cmd_data.status      = ST_OK;
            cmd_data.track_index = to_track_index(sel_idx);
            cmd_data.delta       = s2_sector_reg - sel_first;
            cmd_data.raw_size    = sel_raw;
            cmd_data.base        = sel_base;
            cmd_data.data_offset = sel_offset;
        end
        else
        begin
            cmd_data.status     = ST_MISS;
            cmd_data.first_miss = !miss_reported_reg;
        end
        cmd_push = s2_fire;
    end

    // control next state
    always_comb
    begin
        s1_v_next          = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_v_reg);
        s2_v_next          = s1_fire ? 1'b1 : (s2_fire ? 1'b0 : s2_v_reg);
        ent_count_next     = app_write ? ent_count_reg + CNT_W'(1) : ent_count_reg;
        miss_reported_next = miss_reported_reg || (s2_fire && is_miss);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg          <= 1'b0;
            s2_v_reg          <= 1'b0;
            ent_count_reg     <= '0;
            miss_reported_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg          <= s1_v_next;
            s2_v_reg          <= s2_v_next;
            ent_count_reg     <= ent_count_next;
            miss_reported_reg <= miss_reported_next;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dflt_first_reg  <= '0;
            dflt_base_reg   <= '0;
            dflt_raw_reg    <= DEFAULT_RAW_SIZE_RST;
            dflt_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIRST_SECTOR: dflt_first_reg  <= cfg_data[SECTOR_W-1:0];
                CFG_FILE_BASE:    dflt_base_reg   <= cfg_data;
                CFG_RAW_SIZE:     dflt_raw_reg    <= cfg_data[SIZE_W-1:0];
                CFG_DATA_OFFSET:  dflt_offset_reg <= cfg_data[SIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg   <= func;
            s1_sector_reg <= sector;
            s1_count_reg  <= sector_count;
            s1_base_reg   <= track_file_base;
            s1_raw_reg    <= track_raw_size;
            s1_offset_reg <= track_data_offset;
        end
        if (s1_fire)
        begin
            s2_append_reg <= (s1_func_reg == FUNC_APPEND);
            s2_status_reg <= app_status;
            s2_slot_reg   <= app_slot;
            s2_hit_reg    <= hit;
            s2_sector_reg <= s1_sector_reg;
            s2_dflt_reg   <= (ent_count_reg == '0);
        end
    end

    // table append
    always_ff @(posedge clk)
    begin
        if (app_write)
        begin
            ent_first_reg[app_slot]  <= s1_sector_reg;
            ent_last_reg[app_slot]   <= app_last;
            ent_base_reg[app_slot]   <= s1_base_reg;
            ent_raw_reg[app_slot]    <= s1_raw_reg;
            ent_offset_reg[app_slot] <= s1_offset_reg;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ent_count_reg <= CNT_W'(MAX_TRACKS))
        else $error("track table count beyond capacity");

    a_miss_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        miss_reported_reg |=> miss_reported_reg)
        else $error("miss flag cleared after being set");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (ent_count_reg != $past(ent_count_reg))
            |-> (ent_count_reg == CNT_W'($past(ent_count_reg) + 1'b1)))
        else $error("track table count moved by other than one");
`endif

endmodule

`default_nettype wire

FILE: design/dsfm_cmd_queue.sv
`default_nettype none

module dsfm_cmd_queue
    import dsfm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_data,
    output logic      wr_ready,
    output logic      rd_valid,
    output cmd_t      rd_data,
    input  wire logic rd_en
);

    cmd_t                q_mem_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0] count_reg, count_next;
    logic                do_wr, do_rd;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ready    = (count_reg < CQ_CNT_W'(CQ_DEPTH));
        rd_valid    = (count_reg != '0);
        do_wr       = wr_en && wr_ready;
        do_rd       = rd_en && rd_valid;
        wr_ptr_next = do_wr ? wr_ptr_reg + CQ_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + CQ_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CQ_CNT_W'(do_wr) - CQ_CNT_W'(do_rd);
        rd_data     = q_mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            q_mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

FILE: design/dsfm_back.sv
`default_nettype none

module dsfm_back
    import dsfm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    input  wire cmd_t cmd_data,
    output logic      cmd_pop,
    output logic      empty,
    input  wire logic pop,
    output res_t      res_data
);

    // multiply stage
    logic              m_v_reg, m_v_next;
    logic [PROD_W-1:0] m_prod_reg;
    logic [POS_W-1:0]  m_base_reg;
    logic [SIZE_W-1:0] m_offset_reg;
    res_t              m_res_reg;

    // result queue
    res_t                oq_mem_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] oq_wr_ptr_reg, oq_wr_ptr_next;
    logic [OQ_PTR_W-1:0] oq_rd_ptr_reg, oq_rd_ptr_next;
    logic [OQ_CNT_W-1:0] oq_count_reg, oq_count_next;

    logic              oq_room, m_ready, oq_push, oq_pop;
    logic [PROD_W-1:0] prod;
    res_t              cmd_res;
    res_t              done_res;

    // stage advance
    always_comb
    begin
        oq_room = (oq_count_reg < OQ_CNT_W'(OQ_DEPTH));
        m_ready = !m_v_reg || oq_room;
        cmd_pop = cmd_valid && m_ready;
        oq_push = m_v_reg && oq_room;
        empty   = (oq_count_reg == '0);
        oq_pop  = pop && !empty;
    end

    // sector delta times raw size
    always_comb
    begin
        prod                  = PROD_W'(cmd_data.delta) * PROD_W'(cmd_data.raw_size);
        cmd_res               = '0;
        cmd_res.status        = cmd_data.status;
        cmd_res.used_default  = cmd_data.used_default;
        cmd_res.track_index   = cmd_data.track_index;
        cmd_res.first_miss    = cmd_data.first_miss;
    end

    // final position modulo 2^40
    always_comb
    begin
        done_res               = m_res_reg;
        done_res.byte_position = m_base_reg + m_prod_reg[POS_W-1:0]
                               + POS_W'(m_offset_reg);
    end

    // control next state
    always_comb
    begin
        m_v_next       = cmd_pop ? 1'b1 : (oq_push ? 1'b0 : m_v_reg);
        oq_wr_ptr_next = oq_push ? oq_wr_ptr_reg + OQ_PTR_W'(1) : oq_wr_ptr_reg;
        oq_rd_ptr_next = oq_pop ? oq_rd_ptr_reg + OQ_PTR_W'(1) : oq_rd_ptr_reg;
        oq_count_next  = oq_count_reg + OQ_CNT_W'(oq_push) - OQ_CNT_W'(oq_pop);
        res_data       = oq_mem_reg[oq_rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_v_reg       <= 1'b0;
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_count_reg  <= '0;
        end
        else
        begin
            m_v_reg       <= m_v_next;
            oq_wr_ptr_reg <= oq_wr_ptr_next;
            oq_rd_ptr_reg <= oq_rd_ptr_next;
            oq_count_reg  <= oq_count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            m_prod_reg   <= prod;
            m_base_reg   <= cmd_data.base;
            m_offset_reg <= cmd_data.data_offset;
            m_res_reg    <= cmd_res;
        end
        if (oq_push)
            oq_mem_reg[oq_wr_ptr_reg] <= done_res;
    end

`ifndef SYNTHESIS
    a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        oq_count_reg <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue overfilled");

    a_m_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_v_reg && !oq_room) |=> (m_v_reg && $stable(m_prod_reg)))
        else $error("multiply stage lost its beat while stalled");

    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        oq_push |=> !empty)
        else $error("result pushed but queue reads empty");
`endif

endmodule

`default_nettype wire

FILE: test/sector_map_checker.sv
module sector_map_checker
    import dsfm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  logic                func,
    input  logic [SECTOR_W-1:0] sector,
    input  logic [SECTOR_W-1:0] sector_count,
    input  logic [POS_W-1:0]    track_file_base,
    input  logic [SIZE_W-1:0]   track_raw_size,
    input  logic [SIZE_W-1:0]   track_data_offset,
    input  logic                empty,
    input  logic                pop,
    input  logic [1:0]          status,
    input  logic                used_default,
    input  logic [INDEX_W-1:0]  track_index,
    input  logic [POS_W-1:0]    byte_position,
    input  logic                first_miss,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [POS_W-1:0]    cfg_data,
    output int                  mismatches,
    output int                  outstanding,
    output int                  n_checked,
    output int                  n_default,
    output int                  n_missed,
    output int                  n_rejected
);
    timeunit 1ns;
    timeprecision 1ps;

    // default geometry as last written
    logic [SECTOR_W-1:0] dflt_first;
    logic [POS_W-1:0]    dflt_base;
    logic [SIZE_W-1:0]   dflt_raw;
    logic [SIZE_W-1:0]   dflt_offset;

    // own copy of the track table
    logic [SECTOR_W-1:0] ent_first  [MAX_TRACKS];
    logic [SECTOR_W-1:0] ent_last   [MAX_TRACKS];
    logic [POS_W-1:0]    ent_base   [MAX_TRACKS];
    logic [SIZE_W-1:0]   ent_raw    [MAX_TRACKS];
    logic [SIZE_W-1:0]   ent_offset [MAX_TRACKS];
    logic [CNT_W-1:0]    n_entries;
    logic                miss_seen;

    res_t expected_results[$];
    res_t want;

    // user data start, the sector delta wraps at 32 bits, the rest at 40
    function automatic logic [POS_W-1:0] byte_at(
        input logic [POS_W-1:0]    base,
        input logic [SECTOR_W-1:0] sec,
        input logic [SECTOR_W-1:0] first,
        input logic [SIZE_W-1:0]   raw,
        input logic [SIZE_W-1:0]   offset
    );
        logic [SECTOR_W-1:0] diff;
        logic [POS_W-1:0]    delta;
        logic [POS_W-1:0]    size;
        logic [POS_W-1:0]    skip;
        diff  = sec - first;
        delta = POS_W'(diff);
        size  = POS_W'(raw);
        skip  = POS_W'(offset);
        return base + delta * size + skip;
    endfunction

    // one input beat against the table, updates the table on append
    function automatic res_t map_item(
        input logic                f,
        input logic [SECTOR_W-1:0] sec,
        input logic [SECTOR_W-1:0] cnt,
        input logic [POS_W-1:0]    base,
        input logic [SIZE_W-1:0]   raw,
        input logic [SIZE_W-1:0]   offset
    );
        res_t r;
        int   hit;
        r = '0;
        r.status = ST_OK;
        if (f == FUNC_APPEND) begin
            if (cnt == 0) begin
                r.status = ST_EMPTY;
                n_rejected++;
            end
            else if (n_entries >= MAX_TRACKS) begin
                r.status = ST_FULL;
                n_rejected++;
            end
            else begin
                ent_first[n_entries]  = sec;
                ent_last[n_entries]   = sec + cnt - 1;
                ent_base[n_entries]   = base;
                ent_raw[n_entries]    = raw;
                ent_offset[n_entries] = offset;
                r.track_index = n_entries[INDEX_W-1:0];
                n_entries++;
            end
        end
        else if (n_entries == 0) begin
            r.used_default  = 1'b1;
            r.byte_position = byte_at(dflt_base, sec, dflt_first, dflt_raw, dflt_offset);
            n_default++;
        end
        else begin
            // first entry in append order wins
            hit = -1;
            for (int i = 0; i < MAX_TRACKS; i++) begin
                if (hit < 0 && i < n_entries && sec >= ent_first[i] && sec <= ent_last[i])
                    hit = i;
            end
            if (hit >= 0) begin
                r.track_index   = hit[INDEX_W-1:0];
                r.byte_position = byte_at(ent_base[hit], sec, ent_first[hit],
                                          ent_raw[hit], ent_offset[hit]);
            end
            else begin
                r.status = ST_MISS;
                n_missed++;
                if (!miss_seen) begin
                    r.first_miss = 1'b1;
                    miss_seen    = 1'b1;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dflt_first  = '0;
            dflt_base   = '0;
            dflt_raw    = 12'd2048;
            dflt_offset = '0;
            n_entries   = '0;
            miss_seen   = 1'b0;
            expected_results.delete();
            mismatches  = 0;
            outstanding = 0;
            n_checked   = 0;
            n_default   = 0;
            n_missed    = 0;
            n_rejected  = 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FIRST_SECTOR: dflt_first  = cfg_data[SECTOR_W-1:0];
                    CFG_FILE_BASE:    dflt_base   = cfg_data;
                    CFG_RAW_SIZE:     dflt_raw    = cfg_data[SIZE_W-1:0];
                    CFG_DATA_OFFSET:  dflt_offset = cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end

            // result beat against the oldest expectation
            if (pop && !empty)
            begin
                n_checked++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing expected (status %0d pos %h)",
                                 $realtime, status, byte_position);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status || used_default !== want.used_default ||
                        track_index !== want.track_index ||
                        byte_position !== want.byte_position ||
                        first_miss !== want.first_miss)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: result %0d expected st %0d dflt %0b idx %0d ",
                                      "pos %h fm %0b, got st %0d dflt %0b idx %0d pos %h fm %0b"},
                                     $realtime, n_checked, want.status, want.used_default,
                                     want.track_index, want.byte_position, want.first_miss,
                                     status, used_default, track_index, byte_position,
                                     first_miss);
                    end
                end
            end

            // input beat
            if (push && !full)
                expected_results.push_back(map_item(func, sector, sector_count,
                                                    track_file_base, track_raw_size,
                                                    track_data_offset));
            outstanding = expected_results.size();
        end
    end

endmodule

FILE: test/disc_sector_to_file_offset_mapper_unit_tb.sv
module disc_sector_to_file_offset_mapper_unit_tb;
    import dsfm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    logic                clk               = 1'b0;
    logic                rst_n             = 1'b0;
    logic                push              = 1'b0;
    logic                func              = FUNC_TRANSLATE;
    logic [SECTOR_W-1:0] sector            = '0;
    logic [SECTOR_W-1:0] sector_count      = '0;
    logic [POS_W-1:0]    track_file_base   = '0;
    logic [SIZE_W-1:0]   track_raw_size    = 12'd2048;
    logic [SIZE_W-1:0]   track_data_offset = '0;
    logic                pop               = 1'b0;
    logic                cfg_we            = 1'b0;
    logic [1:0]          cfg_index         = CFG_FIRST_SECTOR;
    logic [POS_W-1:0]    cfg_data          = '0;

    logic                full;
    logic                empty;
    logic [1:0]          status;
    logic                used_default;
    logic [INDEX_W-1:0]  track_index;
    logic [POS_W-1:0]    byte_position;
    logic                first_miss;

    int mismatches;
    int outstanding;
    int n_checked;
    int n_default;
    int n_missed;
    int n_rejected;

    // idle odds in percent for each side
    int send_idle = 30;
    int recv_idle = 65;
    int cycles    = 0;

    // ranges appended so far, used to aim lookups
    logic [SECTOR_W-1:0] trk_first [MAX_TRACKS];
    logic [SECTOR_W-1:0] trk_count [MAX_TRACKS];
    int                  n_tracks = 0;

    disc_sector_to_file_offset_mapper_unit dut (.*);

    sector_map_checker checker_i (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver side
    always @(negedge clk)
        pop <= ($urandom_range(99) >= recv_idle);

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("disc_sector_to_file_offset_mapper_unit: mismatch");
            $finish;
        end
    end

    function automatic logic [POS_W-1:0] rand40();
        logic [POS_W-1:0] v;
        v = POS_W'({$urandom, $urandom});
        return v;
    endfunction

    function automatic logic [SIZE_W-1:0] rand_raw();
        return SIZE_W'($urandom_range(1, 4095));
    endfunction

    function automatic logic [SIZE_W-1:0] rand_offset();
        return SIZE_W'($urandom_range(4095));
    endfunction

    // one input beat, held until taken; called and left at a falling edge
    task automatic send_beat(
        input logic                f,
        input logic [SECTOR_W-1:0] sec,
        input logic [SECTOR_W-1:0] cnt,
        input logic [POS_W-1:0]    base,
        input logic [SIZE_W-1:0]   raw,
        input logic [SIZE_W-1:0]   offset
    );
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push              <= 1'b1;
        func              <= f;
        sector            <= sec;
        sector_count      <= cnt;
        track_file_base   <= base;
        track_raw_size    <= raw;
        track_data_offset <= offset;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    // translate beat, the unused fields get noise
    task automatic lookup(input logic [SECTOR_W-1:0] sec);
        send_beat(FUNC_TRANSLATE, sec, $urandom, rand40(), rand_raw(), rand_offset());
    endtask

    task automatic add_track(
        input logic [SECTOR_W-1:0] first,
        input logic [SECTOR_W-1:0] cnt,
        input logic [POS_W-1:0]    base,
        input logic [SIZE_W-1:0]   raw,
        input logic [SIZE_W-1:0]   offset
    );
        if (cnt != 0 && n_tracks < MAX_TRACKS)
        begin
            trk_first[n_tracks] = first;
            trk_count[n_tracks] = cnt;
            n_tracks++;
        end
        send_beat(FUNC_APPEND, first, cnt, base, raw, offset);
    endtask

    // stop sending and let every result drain
    task automatic wait_idle();
        push <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_default_geometry(
        input logic [SECTOR_W-1:0] first,
        input logic [POS_W-1:0]    base,
        input logic [SIZE_W-1:0]   raw,
        input logic [SIZE_W-1:0]   offset
    );
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FIRST_SECTOR;
        cfg_data  <= {8'b0, first};
        @(negedge clk);
        cfg_index <= CFG_FILE_BASE;
        cfg_data  <= base;
        @(negedge clk);
        cfg_index <= CFG_RAW_SIZE;
        cfg_data  <= {28'b0, raw};
        @(negedge clk);
        cfg_index <= CFG_DATA_OFFSET;
        cfg_data  <= {28'b0, offset};
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly lookups aimed at range edges and insides, some noise and appends
    task automatic random_item(input bit keep_empty);
        int                  pick;
        int                  i;
        logic [SECTOR_W-1:0] s;
        logic [SECTOR_W-1:0] c;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            case ($urandom_range(4))
                0:       c = '0;
                1, 2:    c = $urandom_range(1, 4096);
                default: c = $urandom;
            endcase
            if (keep_empty)
                c = '0;
            add_track($urandom, c, rand40(), rand_raw(), rand_offset());
        end
        else if (pick < 25 || n_tracks == 0)
            lookup($urandom);
        else
        begin
            i = $urandom_range(n_tracks - 1);
            case ($urandom_range(3))
                0: s = trk_first[i];
                1: s = trk_first[i] + trk_count[i] - 1;
                2: s = trk_first[i] + ($urandom % trk_count[i]);
                default: s = $urandom_range(1) ? trk_first[i] - 1 : trk_first[i] + trk_count[i];
            endcase
            lookup(s);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table with the reset geometry
        lookup('0);
        lookup('1);
        send_beat(FUNC_APPEND, 32'd5, '0, rand40(), 12'd2352, 12'd24);
        lookup(32'd7);

        // geometry extremes
        set_default_geometry('1, '1, 12'd4095, 12'd4095);
        lookup('0);
        lookup('1);
        lookup(32'h1234_5678);
        set_default_geometry('0, '0, 12'd1, '0);
        lookup('1);
        lookup('0);

        // random geometries while the table stays empty
        repeat (4)
        begin
            set_default_geometry($urandom, rand40(), rand_raw(), rand_offset());
            repeat (50) random_item(1'b1);
        end

        // first entries: edges, misses, overlap, wrapped ranges, big deltas
        add_track(32'd100, 32'd50, rand40(), 12'd2352, 12'd24);
        lookup(32'd100);
        lookup(32'd149);
        lookup(32'd150);
        lookup(32'd99);
        add_track(32'd120, 32'd100, rand40(), 12'd2336, 12'd16);
        lookup(32'd130);
        lookup(32'd219);
        lookup(32'd220);
        add_track(32'hFFFF_FFF0, 32'd16, '1, 12'd4095, 12'd4095);
        lookup('1);
        add_track(32'hFFFF_FF00, 32'h200, rand40(), 12'd2048, '0);
        lookup(32'hFFFF_FF10);
        add_track('0, 32'd1, '0, 12'd1, '0);
        lookup('0);
        add_track(32'h8000_0000, 32'h7FFF_FFFF, rand40(), 12'd4095, 12'd4095);
        lookup(32'hFFFF_FFEF);
        lookup(32'hFFFF_FFFE);
        add_track(32'h10, '1, rand40(), 12'd2048, '0);
        lookup(32'h10);

        // fill the rest of the table at random
        while (n_tracks < MAX_TRACKS)
            repeat (15) random_item(1'b0);

        // zero count is checked before the full table
        send_beat(FUNC_APPEND, $urandom, '0, rand40(), 12'd2048, '0);
        send_beat(FUNC_APPEND, $urandom, 32'd5, rand40(), 12'd2048, '0);

        // full table, sender slow then both fast
        send_idle = 65;
        recv_idle = 30;
        repeat (800) random_item(1'b0);
        send_idle = 0;
        recv_idle = 0;
        repeat (800) random_item(1'b0);

        wait_idle();
        repeat (20) @(negedge clk);

        $display("checked %0d result beats: %0d default-geometry lookups, %0d misses,",
                 n_checked, n_default, n_missed);
        $display("%0d rejected appends, %0d table entries, 6 default geometries",
                 n_rejected, n_tracks);
        if (mismatches == 0 && outstanding == 0)
            $display("disc_sector_to_file_offset_mapper_unit: match");
        else
            $display("disc_sector_to_file_offset_mapper_unit: mismatch");
        $finish;
    end

endmodule
